/* design/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the URL percent decoder
// Beat types for both channels, escape phase codes, character constants and
// the hex digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

  // input beat: one encoded character
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // output beat: one decoded byte, or the terminator
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_end;
    logic [15:0] out_count;
  } out_t;

  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned MaxResults       = 4;
  localparam logic [15:0] CapResetValue    = 16'd64;

  // escape phase codes
  localparam logic [1:0] PhasePlain    = 2'd0;
  localparam logic [1:0] PhaseAfterPct = 2'd1;
  localparam logic [1:0] PhaseOneDigit = 2'd2;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperF  = 8'h46;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerF  = 8'h66;
  localparam logic [7:0] CaseGap   = 8'h20;  // 'a' - 'A'
  localparam logic [7:0] AlphaBase = 8'h37;  // 'A' - 10

  function automatic logic is_hex(input logic [7:0] c);
    logic res;
    res = ((c >= ChZero) && (c <= ChNine)) ||
          ((c >= ChUpperA) && (c <= ChUpperF)) ||
          ((c >= ChLowerA) && (c <= ChLowerF));
    return res;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] v;
    u = (c >= ChLowerA) ? (c - CaseGap) : c;
    v = (u >= ChUpperA) ? (u - AlphaBase) : (u - ChZero);
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

/* design/url_percent_decoder_unit.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder_unit: streaming URL percent decoder
// Decodes %XX escapes and '+' into bytes, closes each string with a
// terminator beat carrying the number of kept bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one encoded
//   character per beat, with in_last on the final one. Output channel
//   out_valid_o / out_stall_i / out_data_o carries decoded bytes and, at the
//   end of each string, a terminator beat (out_end set, out_count = total).
//   cfg_we_i / cfg_data_i write the destination capacity (reset 64); write
//   it only while the decoder is idle.
// Data path and throughput:
//   A beat lands in the input register and is decoded into a four entry
//   result buffer once that buffer drains; the output reads its registers.
//   One input beat per cycle is sustained while each beat yields at most one
//   result and the output does not stall; a beat yielding more results holds
//   the buffer until the single output port has drained it, one per cycle.
// Reset:
//   Clears the escape state, the kept count, the ended flag, both buffers
//   and sets the capacity to 64.
// Stalls:
//   A stalled output holds its beat; the input register still takes one
//   more beat, then in_stall_o rises until the result buffer drains.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_unit #(
  parameter int unsigned COUNT_BITS = upd_pkg::CountBitsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire upd_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output upd_pkg::out_t     out_data_o,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_data_i
);

  localparam int unsigned LimW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int unsigned NRes = upd_pkg::MaxResults;
  localparam int unsigned IdxW = $clog2(NRes);
  localparam int unsigned NumW = $clog2(NRes + 1);

  // configuration
  logic [15:0] cap_q;

  // input register
  logic         in_full_q, in_full_d;
  upd_pkg::in_t in_q;
  logic         in_accept;

  // stream state
  logic [1:0]            phase_q, phase_d;
  logic [7:0]            held_q, held_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  ended_q, ended_d;

  // result buffer
  upd_pkg::out_t res_q [NRes];
  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] idx_q, idx_d;
  logic            out_pop;
  logic            buf_empty;
  logic            load;

  // decode
  logic [7:0]      cand [NRes];
  logic [NumW-1:0] k_n;
  logic            term;
  logic            clear_cnt;
  logic [7:0]      c;
  logic            do_finish;

  // limit and room
  logic [LimW-1:0]       count_max;
  logic [LimW-1:0]       lim_cap;
  logic [LimW-1:0]       limit;
  logic [LimW-1:0]       cnt_ext;
  logic [LimW-1:0]       diff;
  logic [NumW-1:0]       room;
  logic [NumW-1:0]       kept;
  logic [COUNT_BITS-1:0] cnt_new;
  upd_pkg::out_t         res_d [NRes];

  // handshake
  assign out_valid_o = (idx_q != num_q);
  assign out_data_o  = res_q[idx_q[IdxW-1:0]];
  assign out_pop     = out_valid_o & ~out_stall_i;
  assign buf_empty   = ~out_valid_o;
  assign load        = in_full_q &
                       (buf_empty | (out_pop & ((idx_q + NumW'(1)) == num_q)));
  assign in_stall_o  = in_full_q & ~load;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign in_full_d   = in_accept | (in_full_q & ~load);

  // decode one character into candidate bytes and the next state
  always_comb begin
    for (int i = 0; i < NRes; i++) begin
      cand[i] = '0;
    end
    k_n       = '0;
    term      = 1'b0;
    clear_cnt = 1'b0;
    do_finish = 1'b0;
    phase_d   = phase_q;
    held_d    = held_q;
    ended_d   = ended_q;
    c         = in_q.in_byte;

    if (ended_q) begin
      // swallow the rest of a string ended early
      if (in_q.in_last) begin
        ended_d = 1'b0;
      end
    end else if (c == 8'd0) begin
      do_finish = 1'b1;
      ended_d   = ~in_q.in_last;
    end else begin
      case (phase_q)
        upd_pkg::PhaseAfterPct: begin
          if (upd_pkg::is_hex(c)) begin
            held_d  = c;
            phase_d = upd_pkg::PhaseOneDigit;
          end else begin
            // broken escape: literal percent, then c as plain text
            cand[k_n[IdxW-1:0]] = upd_pkg::ChPercent;
            k_n = k_n + NumW'(1);
            phase_d = upd_pkg::PhasePlain;
            if (c == upd_pkg::ChPercent) begin
              phase_d = upd_pkg::PhaseAfterPct;
            end else begin
              cand[k_n[IdxW-1:0]] = (c == upd_pkg::ChPlus) ? upd_pkg::ChSpace : c;
              k_n = k_n + NumW'(1);
            end
          end
        end
        upd_pkg::PhaseOneDigit: begin
          phase_d = upd_pkg::PhasePlain;
          if (upd_pkg::is_hex(c)) begin
            cand[k_n[IdxW-1:0]] = {upd_pkg::hex_value(held_q), upd_pkg::hex_value(c)};
            k_n = k_n + NumW'(1);
          end else begin
            // percent, held digit, then c as plain text
            cand[k_n[IdxW-1:0]] = upd_pkg::ChPercent;
            k_n = k_n + NumW'(1);
            cand[k_n[IdxW-1:0]] = held_q;
            k_n = k_n + NumW'(1);
            if (c == upd_pkg::ChPercent) begin
              phase_d = upd_pkg::PhaseAfterPct;
            end else begin
              cand[k_n[IdxW-1:0]] = (c == upd_pkg::ChPlus) ? upd_pkg::ChSpace : c;
              k_n = k_n + NumW'(1);
            end
          end
        end
        default: begin
          phase_d = upd_pkg::PhasePlain;
          if (c == upd_pkg::ChPercent) begin
            phase_d = upd_pkg::PhaseAfterPct;
          end else begin
            cand[k_n[IdxW-1:0]] = (c == upd_pkg::ChPlus) ? upd_pkg::ChSpace : c;
            k_n = k_n + NumW'(1);
          end
        end
      endcase
      do_finish = in_q.in_last;
    end

    // flush a pending escape and close the string
    if (do_finish) begin
      if (phase_d == upd_pkg::PhaseAfterPct) begin
        cand[k_n[IdxW-1:0]] = upd_pkg::ChPercent;
        k_n = k_n + NumW'(1);
      end else if (phase_d == upd_pkg::PhaseOneDigit) begin
        cand[k_n[IdxW-1:0]] = upd_pkg::ChPercent;
        k_n = k_n + NumW'(1);
        if (k_n < NumW'(NRes)) begin
          cand[k_n[IdxW-1:0]] = held_d;
          k_n = k_n + NumW'(1);
        end
      end
      term      = 1'b1;
      clear_cnt = 1'b1;
      phase_d   = upd_pkg::PhasePlain;
      held_d    = '0;
    end
  end

  // capacity limit and how many candidates still fit
  always_comb begin
    count_max = LimW'({COUNT_BITS{1'b1}});
    lim_cap   = (cap_q == 16'd0) ? '0 : LimW'(cap_q - 16'd1);
    limit     = (lim_cap > count_max) ? count_max : lim_cap;
    cnt_ext   = LimW'(cnt_q);
    diff      = limit - cnt_ext;
    if (limit <= cnt_ext) begin
      room = '0;
    end else if (diff >= LimW'(NRes)) begin
      room = NumW'(NRes);
    end else begin
      room = diff[NumW-1:0];
    end
    kept    = (k_n < room) ? k_n : room;
    cnt_new = cnt_q + COUNT_BITS'(kept);
    cnt_d   = clear_cnt ? '0 : cnt_new;
    num_d   = kept + NumW'(term);
  end

  // result buffer contents
  always_comb begin
    for (int i = 0; i < NRes; i++) begin
      logic [LimW-1:0] cnt_i;
      cnt_i = cnt_ext + LimW'(i + 1);
      res_d[i].out_byte  = cand[i];
      res_d[i].out_end   = 1'b0;
      res_d[i].out_count = cnt_i[15:0];
      if ((NumW'(i) == kept) && term) begin
        res_d[i].out_byte  = 8'd0;
        res_d[i].out_end   = 1'b1;
        res_d[i].out_count = cnt_ext[15:0] + 16'(kept);
      end
    end
  end

  // drain pointer
  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = '0;
    end else if (out_pop) begin
      idx_d = idx_q + NumW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= upd_pkg::CapResetValue;
      in_full_q <= 1'b0;
      phase_q   <= upd_pkg::PhasePlain;
      held_q    <= '0;
      cnt_q     <= '0;
      ended_q   <= 1'b0;
      num_q     <= '0;
      idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      in_full_q <= in_full_d;
      idx_q     <= idx_d;
      if (load) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        cnt_q   <= cnt_d;
        ended_q <= ended_d;
        num_q   <= num_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (load) begin
      for (int i = 0; i < NRes; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

endmodule

`default_nettype wire

/* tb/url_percent_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_unit_tb: self-checking bench for the URL percent decoder
// Sends encoded strings with random gaps and output stalls across several
// capacity settings. A scoreboard class tracks its own escape and count
// state, queues the decoded beats due for each accepted character and checks
// every output beat against the oldest one, field by field.
// ----------------------------------------------------------------------------

module url_percent_decoder_unit_tb;
  import upd_pkg::*;

  localparam int unsigned IdlePct      = 14;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned CycleLimit   = 200_000;
  localparam int unsigned ReportCap    = 40;
  localparam logic [7:0]  NulChar      = 8'h00;

  // scoreboard: mirrors the decoder state and holds the beats still due
  class decoded_stream_sb;
    logic [15:0] capacity;
    logic [1:0]  phase;
    logic [7:0]  held_digit;
    logic [15:0] kept;
    bit          ended;
    out_t        awaited[$];
    int unsigned mismatches;
    int unsigned chars_decoded;
    int unsigned beats_checked;
    int unsigned strings_closed;

    function void clear();
      capacity       = CapResetValue;
      phase          = PhasePlain;
      held_digit     = '0;
      kept           = '0;
      ended          = 1'b0;
      mismatches     = 0;
      chars_decoded  = 0;
      beats_checked  = 0;
      strings_closed = 0;
      awaited.delete();
    endfunction

    function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = 4'h0;
      if (c >= "0" && c <= "9") begin
        v = 4'(c - "0");
      end else if (c >= "A" && c <= "F") begin
        v = 4'(c - "A" + 8'd10);
      end else if (c >= "a" && c <= "f") begin
        v = 4'(c - "a" + 8'd10);
      end else begin
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // room is capacity less the terminator; capacity 0 behaves as 1
    function void keep_byte(input logic [7:0] b);
      logic [15:0] room;
      room = (capacity != 16'd0) ? capacity - 16'd1 : 16'd0;
      if (kept >= room) return;
      kept++;
      awaited.push_back('{out_byte: b, out_end: 1'b0, out_count: kept});
    endfunction

    function void plain_char(input logic [7:0] c);
      if (c == ChPercent) phase = PhaseAfterPct;
      else if (c == ChPlus) keep_byte(ChSpace);
      else keep_byte(c);
    endfunction

    function void feed_char(input logic [7:0] c);
      logic [3:0] hi;
      logic [3:0] lo;
      case (phase)
        PhaseAfterPct: begin
          if (hex_nibble(c, lo)) begin
            held_digit = c;
            phase      = PhaseOneDigit;
          end else begin
            phase = PhasePlain;
            keep_byte(ChPercent);
            plain_char(c);
          end
        end
        PhaseOneDigit: begin
          phase = PhasePlain;
          if (hex_nibble(c, lo)) begin
            void'(hex_nibble(held_digit, hi));
            keep_byte({hi, lo});
          end else begin
            // broken escape: percent, then the held digit and this byte afresh
            keep_byte(ChPercent);
            plain_char(held_digit);
            plain_char(c);
          end
        end
        default: plain_char(c);
      endcase
    endfunction

    // flush a pending escape, then the terminator with the total
    function void close_string();
      if (phase == PhaseAfterPct) begin
        keep_byte(ChPercent);
      end else if (phase == PhaseOneDigit) begin
        keep_byte(ChPercent);
        keep_byte(held_digit);
      end
      awaited.push_back('{out_byte: 8'h00, out_end: 1'b1, out_count: kept});
      strings_closed++;
      phase      = PhasePlain;
      held_digit = '0;
      kept       = '0;
    endfunction

    function void take_char(input in_t beat);
      // after an early zero, skip up to and including the last-flagged byte
      if (ended) begin
        if (beat.in_last) ended = 1'b0;
        return;
      end
      chars_decoded++;
      if (beat.in_byte == NulChar) begin
        close_string();
        ended = !beat.in_last;
        return;
      end
      feed_char(beat.in_byte);
      if (beat.in_last) close_string();
    endfunction

    task report(input string what);
      mismatches++;
      if (mismatches <= ReportCap) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task match_beat(input out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        report($sformatf("beat with nothing due: byte %02h end %0b count %0d",
                         got.out_byte, got.out_end, got.out_count));
        return;
      end
      want = awaited.pop_front();
      beats_checked++;
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, due %02h", got.out_byte, want.out_byte));
      if (got.out_end !== want.out_end)
        report($sformatf("out_end %0b, due %0b", got.out_end, want.out_end));
      if (got.out_count !== want.out_count)
        report($sformatf("out_count %0d, due %0d", got.out_count, want.out_count));
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_data_i  = '0;

  bit              calm = 1'b0;
  int unsigned     cycle_count = 0;
  decoded_stream_sb sb;

  url_percent_decoder_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  // random output stalls, none while calm
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  // beat monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_char(in_data_i);
      if (out_valid_o && !out_stall_i) sb.match_beat(out_data_o);
    end
  end

  function automatic logic [7:0] pick_hex();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    case ($urandom_range(0, 3))
      0:       return 8'("G" + $urandom_range(0, 19));
      1:       return ChPercent;
      2:       return ChPlus;
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return ChPercent;
    if (r < 45) return pick_hex();
    if (r < 53) return ChPlus;
    if (r < 55) return NulChar;
    return 8'($urandom_range(1, 255));
  endfunction

  // one beat, held until accepted; valid stays high afterwards
  task automatic send_char(input logic [7:0] b, input bit last);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, in_last: last};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], last && (i == s.len() - 1));
  endtask

  // escapes, plus signs and random bytes, now and then a broken escape or a zero
  task automatic send_random_string();
    logic [7:0]  text[$];
    int unsigned segs;
    segs = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    repeat (segs) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          text.push_back(ChPercent);
          text.push_back(pick_hex());
          text.push_back(pick_hex());
        end
        3: begin
          text.push_back(ChPercent);
          if ($urandom_range(0, 1)) text.push_back(pick_hex());
          text.push_back(pick_non_hex());
        end
        default: text.push_back(pick_char());
      endcase
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic run_random(input int unsigned n_chars);
    int unsigned goal;
    goal = sb.chars_decoded + n_chars;
    while (sb.chars_decoded < goal) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: any byte, last flag at random
        repeat ($urandom_range(1, 6))
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      end else begin
        send_random_string();
      end
    end
    send_random_string();
  endtask

  // hold off until every due beat is back, then let the pipe settle
  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.capacity = value;
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings at the reset capacity
    send_text("%41%fF+%G", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h01, 1'b1);
    send_text("%%4Z", 1'b1);   // double percent, then broken escape at the end
    send_text("%4%", 1'b1);    // broken escape that opens another one
    send_text("%A", 1'b1);     // ends holding one digit
    send_text("x", 1'b0);
    send_char(NulChar, 1'b0);  // early end, rest skipped
    send_text("yz", 1'b1);
    send_char(NulChar, 1'b1);
    drain_decoder();

    write_capacity(16'd0);
    run_random(20);
    drain_decoder();

    write_capacity(16'd1);
    run_random(20);
    drain_decoder();

    calm = 1'b1;
    write_capacity(16'hFFFF);
    run_random(40);
    drain_decoder();
    calm = 1'b0;

    write_capacity(16'd3);
    run_random(20);
    drain_decoder();
    run_random(20);
    drain_decoder();

    write_capacity(16'd17);
    run_random(30);
    drain_decoder();

    write_capacity(CapResetValue);
    run_random(30);
    drain_decoder();

    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d beats never arrived", sb.awaited.size()));
    $display("Decoded %0d characters into %0d strings; %0d output beats checked.",
             sb.chars_decoded, sb.strings_closed, sb.beats_checked);
    $display("Capacities 64, 0, 1, 65535, 3 and 17; escapes, plus, early zero ends.");
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
